// ===== rtl/core/sgr_pkg.sv =====
// Shared types, byte codes and parameter decode for the SGR attribute parser.
`timescale 1ns / 1ps

package sgr_pkg;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_DIG1   = 8'h31;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    localparam logic [7:0] P_RESET        = 8'd0;
    localparam logic [7:0] P_STANDOUT     = 8'd1;
    localparam logic [7:0] P_DIM          = 8'd2;
    localparam logic [7:0] P_UNDERLINE    = 8'd4;
    localparam logic [7:0] P_BLINK_SLOW   = 8'd5;
    localparam logic [7:0] P_BLINK_FAST   = 8'd6;
    localparam logic [7:0] P_REVERSE      = 8'd7;
    localparam logic [7:0] P_NORMAL_INT   = 8'd22;
    localparam logic [7:0] P_NO_UNDERLINE = 8'd24;
    localparam logic [7:0] P_NO_BLINK     = 8'd25;
    localparam logic [7:0] P_NO_REVERSE   = 8'd27;
    localparam logic [7:0] P_FG_FIRST     = 8'd30;
    localparam logic [7:0] P_FG_LAST      = 8'd37;
    localparam logic [7:0] P_BG_FIRST     = 8'd40;
    localparam logic [7:0] P_BG_LAST      = 8'd47;

    localparam logic [7:0] PARAM_MAX = 8'd255;

    localparam int FLAG_STANDOUT  = 0;
    localparam int FLAG_DIM       = 1;
    localparam int FLAG_UNDERLINE = 2;
    localparam int FLAG_BLINK     = 3;
    localparam int FLAG_REVERSE   = 4;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic [4:0] flags;
        logic [2:0] fore;
        logic [2:0] back;
    } t_attr;

    function automatic logic is_final_letter(input logic [7:0] b);
        return ((b >= CH_UC_A) && (b <= CH_UC_Z)) || ((b >= CH_LC_A) && (b <= CH_LC_Z));
    endfunction

    // Apply one finished SGR parameter to an attribute set.
    function automatic t_attr apply_param(input logic [7:0] v, input t_attr a);
        t_attr      r;
        logic [7:0] fg_off;
        logic [7:0] bg_off;
        r      = a;
        fg_off = v - P_FG_FIRST;
        bg_off = v - P_BG_FIRST;
        if (v == P_RESET)                          r.flags = '0;
        if (v == P_STANDOUT)                       r.flags[FLAG_STANDOUT] = 1'b1;
        if (v == P_DIM)                            r.flags[FLAG_DIM] = 1'b1;
        if (v == P_UNDERLINE)                      r.flags[FLAG_UNDERLINE] = 1'b1;
        if (v == P_BLINK_SLOW || v == P_BLINK_FAST) r.flags[FLAG_BLINK] = 1'b1;
        if (v == P_REVERSE)                        r.flags[FLAG_REVERSE] = 1'b1;
        if (v == P_NORMAL_INT) begin
            r.flags[FLAG_STANDOUT] = 1'b0;
            r.flags[FLAG_DIM]      = 1'b0;
        end
        if (v == P_NO_UNDERLINE)                   r.flags[FLAG_UNDERLINE] = 1'b0;
        if (v == P_NO_BLINK)                       r.flags[FLAG_BLINK] = 1'b0;
        if (v == P_NO_REVERSE)                     r.flags[FLAG_REVERSE] = 1'b0;
        if (v >= P_FG_FIRST && v <= P_FG_LAST)     r.fore = fg_off[2:0];
        if (v >= P_BG_FIRST && v <= P_BG_LAST)     r.back = bg_off[2:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/ansi_sgr_attribute_parser_core.sv =====
// Top level of the SGR attribute parser: input register, decode/update, result register.
`timescale 1ns / 1ps

// Takes one text byte per cycle and returns at most one result word per byte; with no
// stall on the result side it sustains one byte per clock. A byte is held in the
// input register, is decoded there against the parser state in one pass of logic,
// and its result is then registered in the result register; a stall on the result
// side holds a byte that has a result in the input register. ESC sequences, digits,
// ';', '[' and the closing 'm', as well as NUL outside a sequence, update state only
// and produce no word; a closing letter other than 'm', or NUL inside a sequence,
// produces an error word with kind set. Raising new_text with a byte clears all
// attributes, colours and any open sequence before that byte is decoded.
module ansi_sgr_attribute_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_new_text,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_glyph,
    output logic [2:0] o_fore_colour,
    output logic [2:0] o_back_colour,
    output logic       o_standout_on,
    output logic       o_dim_on,
    output logic       o_underline_on,
    output logic       o_blink_on,
    output logic       o_reverse_on
);
    import sgr_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_new;

    // parser state
    logic       r_in_seq, n_in_seq;
    logic [7:0] r_param, n_param;
    t_attr      r_pending, n_pending;
    t_attr      r_active, n_active;

    // result register
    logic       r_out_valid;
    logic       r_kind, n_kind;
    logic [7:0] r_glyph, n_glyph;
    t_attr      r_out_attr;

    logic       has_result;
    logic       out_free;
    logic       advance;
    logic       in_accept;

    logic       cur_seq;
    logic [7:0] cur_param;
    t_attr      cur_pending;
    t_attr      cur_active;
    t_attr      closed;
    logic [3:0] digit;
    logic [11:0] acc;

    // new_text clears the state seen by this byte
    always_comb begin
        cur_seq     = r_new ? 1'b0 : r_in_seq;
        cur_param   = r_new ? '0 : r_param;
        cur_pending = r_new ? '0 : r_pending;
        cur_active  = r_new ? '0 : r_active;
    end

    always_comb begin
        closed = apply_param(cur_param, cur_pending);
        digit  = ((r_byte >= CH_DIG1) && (r_byte <= CH_DIG9)) ? r_byte[3:0] : 4'd0;
        acc    = {4'd0, cur_param} * 12'd10 + {8'd0, digit};
    end

    always_comb begin
        n_in_seq   = cur_seq;
        n_param    = cur_param;
        n_pending  = cur_pending;
        n_active   = cur_active;
        has_result = 1'b0;
        n_kind     = KIND_CHAR;
        n_glyph    = r_byte;
        if (!cur_seq) begin
            priority if (r_byte == CH_ESC) begin
                n_in_seq  = 1'b1;
                n_param   = '0;
                n_pending = cur_active;
            end else if (r_byte == CH_NUL) begin
                has_result = 1'b0;
            end else begin
                has_result = 1'b1;
            end
        end else begin
            priority if (r_byte == CH_NUL) begin
                n_in_seq   = 1'b0;
                n_param    = '0;
                has_result = 1'b1;
                n_kind     = KIND_ERROR;
            end else if (is_final_letter(r_byte)) begin
                n_in_seq  = 1'b0;
                n_param   = '0;
                n_pending = closed;
                if (r_byte == CH_M) begin
                    n_active = closed;
                end else begin
                    has_result = 1'b1;
                    n_kind     = KIND_ERROR;
                end
            end else if (r_byte == CH_SEMI) begin
                n_pending = closed;
                n_param   = '0;
            end else if (r_byte == CH_LBRACK) begin
                n_param = cur_param;
            end else begin
                n_param = (acc > {4'd0, PARAM_MAX}) ? PARAM_MAX : acc[7:0];
            end
        end
    end

    // words with no result move on even while the result register is held
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!has_result || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte <= i_text_byte;
            r_new  <= i_new_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seq  <= 1'b0;
            r_param   <= '0;
            r_pending <= '0;
            r_active  <= '0;
        end else if (advance) begin
            r_in_seq  <= n_in_seq;
            r_param   <= n_param;
            r_pending <= n_pending;
            r_active  <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_kind     <= n_kind;
            r_glyph    <= n_glyph;
            r_out_attr <= cur_active;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_glyph        = r_glyph;
    assign o_fore_colour  = r_out_attr.fore;
    assign o_back_colour  = r_out_attr.back;
    assign o_standout_on  = r_out_attr.flags[FLAG_STANDOUT];
    assign o_dim_on       = r_out_attr.flags[FLAG_DIM];
    assign o_underline_on = r_out_attr.flags[FLAG_UNDERLINE];
    assign o_blink_on     = r_out_attr.flags[FLAG_BLINK];
    assign o_reverse_on   = r_out_attr.flags[FLAG_REVERSE];

    // a plain character word never carries NUL
    a_char_not_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_CHAR) |-> (o_glyph != CH_NUL))
        else $error("character word carries NUL");

    // error words only for NUL or a closing letter other than m
    a_error_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_ERROR) |->
            (o_glyph == CH_NUL) || (is_final_letter(o_glyph) && (o_glyph != CH_M)))
        else $error("error word with unexpected final byte");

    // parameter accumulator is idle outside a sequence
    a_param_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_seq |-> (r_param == '0))
        else $error("parameter value left over outside a sequence");

    // a held input word keeps the parser state frozen
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_active) && $stable(r_in_seq))
        else $error("parser state moved while input word was held");

    // state comes out of reset cleared
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_seq && (r_active == '0) && !r_in_valid && !r_out_valid)
        else $error("state not cleared by reset");

endmodule
